### hw/rtl/led_pixel_spi_symbol_encoder_defines.svh
// ----------------------------------------------------------------------------
// LED pixel symbol encoder assertion macros
// Concurrent assertion helpers that sample on clk and hold off during reset.
// ----------------------------------------------------------------------------
`ifndef LED_PIXEL_SPI_SYMBOL_ENCODER_DEFINES_SVH
`define LED_PIXEL_SPI_SYMBOL_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check that cond implies expect in the same cycle.
`define LPSSE_ASSERT_SAME(label, cond, expect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect)) \
        else $error("lpsse: same-cycle check failed");
// Check that cond implies expect in the next cycle.
`define LPSSE_ASSERT_NEXT(label, cond, expect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect)) \
        else $error("lpsse: next-cycle check failed");
`else
`define LPSSE_ASSERT_SAME(label, cond, expect)
`define LPSSE_ASSERT_NEXT(label, cond, expect)
`endif

`endif

### hw/rtl/lpsse_pkg.sv
// ----------------------------------------------------------------------------
// LED pixel symbol encoder package
// Field widths, register indexes and the bit-to-symbol encoding function.
// ----------------------------------------------------------------------------
package lpsse_pkg;

    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned SYM_W     = 3;
    localparam int unsigned WORD_W    = CHAN_W * SYM_W;
    localparam int unsigned LED_BYTES = 3 * WORD_W / 8;
    localparam int unsigned FRAME_W   = LED_BYTES * 8;
    localparam int unsigned PROD_W    = 2 * CHAN_W;
    localparam int unsigned CNT_W     = $clog2(LED_BYTES);
    localparam int unsigned IDX_W     = 3;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LED_BYTES - 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // Register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_BRIGHTNESS = 3'd0;
    localparam logic [IDX_W-1:0] REG_SWAP_RG    = 3'd1;
    localparam logic [IDX_W-1:0] REG_INVERT     = 3'd2;
    localparam logic [IDX_W-1:0] REG_ONE_SYM    = 3'd3;
    localparam logic [IDX_W-1:0] REG_ZERO_SYM   = 3'd4;

    localparam logic [CHAN_W-1:0] BRIGHTNESS_RST = 8'd128;
    localparam logic [SYM_W-1:0]  ONE_SYM_RST    = 3'd6;
    localparam logic [SYM_W-1:0]  ZERO_SYM_RST   = 3'd4;

    typedef struct packed {
        logic [CHAN_W-1:0] brightness;
        logic              swap_red_green;
        logic              invert_bytes;
        logic [SYM_W-1:0]  one_symbol;
        logic [SYM_W-1:0]  zero_symbol;
    } cfg_regs_t;

    // floor(p / 255) for p up to 255*255
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] sum;
        sum = {1'b0, p} + {{(CHAN_W + 1){1'b0}}, p[PROD_W-1:CHAN_W]} + (PROD_W + 1)'(1);
        return sum[PROD_W-1:CHAN_W];
    endfunction

    // Color bit b, LSB first, becomes a symbol at bit offset SYM_W*b
    function automatic logic [WORD_W-1:0] encode_channel(
        input logic [CHAN_W-1:0] v,
        input logic [SYM_W-1:0]  one_sym,
        input logic [SYM_W-1:0]  zero_sym
    );
        logic [WORD_W-1:0] word;
        word = '0;
        for (int b = 0; b < CHAN_W; b++)
        begin
            word[SYM_W*b +: SYM_W] = v[b] ? one_sym : zero_sym;
        end
        return word;
    endfunction

endpackage

### hw/rtl/lpsse_if.sv
// ----------------------------------------------------------------------------
// LED pixel symbol encoder channels
// Pixel input, serial byte output and configuration write channels.
// ----------------------------------------------------------------------------
interface lpsse_pixel_if;
    logic                            valid;
    logic                            ready;
    logic [lpsse_pkg::CHAN_W-1:0]    red;
    logic [lpsse_pkg::CHAN_W-1:0]    green;
    logic [lpsse_pkg::CHAN_W-1:0]    blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface lpsse_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  line_byte;
    logic        last_of_led;

    modport source (output valid, output line_byte, output last_of_led, input ready);
    modport sink   (input valid, input line_byte, input last_of_led, output ready);
endinterface

interface lpsse_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lpsse_pkg::IDX_W-1:0]     index;
    logic [7:0]                      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/led_pixel_spi_symbol_encoder.sv
// ----------------------------------------------------------------------------
// LED pixel serial symbol encoder
// Scales an RGB pixel, encodes each color bit as a 3-bit symbol and streams
// the result as nine bytes for a serial data line.
// ----------------------------------------------------------------------------
// Each pixel transfer yields nine byte transfers: red, green and blue slots in
// that order, each slot a 24-bit word of eight 3-bit symbols (LSB first) sent
// low byte first, the ninth byte flagged by last_of_led. A channel is scaled as
// floor(channel * brightness / 255) before encoding; swap_red_green exchanges
// the red and green data, invert_bytes complements every byte. The pipeline
// has four register stages (input capture, multiply, divide-and-encode,
// byte serializer); the capture stage loads at the transfer edge itself, and
// the first byte of a pixel is offered once the pixel reaches the serializer.
// The serializer, which sets the sustained rate, sends one byte per cycle
// while the stream is ready; a new pixel is taken while earlier ones are
// still in flight, and the next frame loads in the cycle the ninth byte leaves.
// Configuration writes are always accepted; write them only while idle.
// Unknown register indexes are ignored.
// ----------------------------------------------------------------------------
`include "led_pixel_spi_symbol_encoder_defines.svh"

module led_pixel_spi_symbol_encoder (
    input  logic           clk,
    input  logic           rst_n,
    lpsse_pixel_if.sink    pixel,
    lpsse_byte_if.source   stream,
    lpsse_cfg_if.sink      cfg
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    lpsse_pkg::cfg_regs_t cfg_reg;
    lpsse_pkg::cfg_regs_t cfg_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                lpsse_pkg::REG_BRIGHTNESS: cfg_next.brightness     = cfg.data;
                lpsse_pkg::REG_SWAP_RG:    cfg_next.swap_red_green = cfg.data[0];
                lpsse_pkg::REG_INVERT:     cfg_next.invert_bytes   = cfg.data[0];
                lpsse_pkg::REG_ONE_SYM:    cfg_next.one_symbol     = cfg.data[2:0];
                lpsse_pkg::REG_ZERO_SYM:   cfg_next.zero_symbol    = cfg.data[2:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brightness     <= lpsse_pkg::BRIGHTNESS_RST;
            cfg_reg.swap_red_green <= 1'b0;
            cfg_reg.invert_bytes   <= 1'b0;
            cfg_reg.one_symbol     <= lpsse_pkg::ONE_SYM_RST;
            cfg_reg.zero_symbol    <= lpsse_pkg::ZERO_SYM_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage valids and back-pressure
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic ser_valid_reg, ser_valid_next;

    logic [lpsse_pkg::CNT_W-1:0]   ser_cnt_reg, ser_cnt_next;
    logic [lpsse_pkg::CNT_W-1:0]   ser_cnt_inc;
    logic [lpsse_pkg::FRAME_W-1:0] ser_frame_reg, ser_frame_next;

    logic ser_last;
    logic out_xfer;
    logic out_stall;
    logic ser_ready;
    logic s3_ready;
    logic s2_ready;
    logic s1_ready;

    assign ser_last    = (ser_cnt_reg == lpsse_pkg::CNT_LAST);
    assign ser_cnt_inc = ser_cnt_reg + lpsse_pkg::CNT_ONE;
    assign out_xfer    = ser_valid_reg && stream.ready;
    assign out_stall   = ser_valid_reg && !stream.ready;
    // The serializer frees up as its ninth byte leaves
    assign ser_ready = !ser_valid_reg || (out_xfer && ser_last);
    assign s3_ready  = !s3_valid_reg || ser_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;

    assign pixel.ready = s1_ready;

    // ------------------------------------------------------------------
    // Stage 1: capture the pixel
    // ------------------------------------------------------------------
    logic [lpsse_pkg::CHAN_W-1:0] s1_red_reg, s1_red_next;
    logic [lpsse_pkg::CHAN_W-1:0] s1_green_reg, s1_green_next;
    logic [lpsse_pkg::CHAN_W-1:0] s1_blue_reg, s1_blue_next;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_red_next   = s1_red_reg;
        s1_green_next = s1_green_reg;
        s1_blue_next  = s1_blue_reg;
        if (s1_ready)
        begin
            s1_valid_next = pixel.valid;
            s1_red_next   = pixel.red;
            s1_green_next = pixel.green;
            s1_blue_next  = pixel.blue;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: multiply each channel by brightness
    // ------------------------------------------------------------------
    logic [lpsse_pkg::PROD_W-1:0] s2_red_reg, s2_red_next;
    logic [lpsse_pkg::PROD_W-1:0] s2_green_reg, s2_green_next;
    logic [lpsse_pkg::PROD_W-1:0] s2_blue_reg, s2_blue_next;
    logic [lpsse_pkg::PROD_W-1:0] gain_wide;

    assign gain_wide = lpsse_pkg::PROD_W'(cfg_reg.brightness);

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        s2_red_next   = s2_red_reg;
        s2_green_next = s2_green_reg;
        s2_blue_next  = s2_blue_reg;
        if (s2_ready)
        begin
            s2_valid_next = s1_valid_reg;
            s2_red_next   = lpsse_pkg::PROD_W'(s1_red_reg) * gain_wide;
            s2_green_next = lpsse_pkg::PROD_W'(s1_green_reg) * gain_wide;
            s2_blue_next  = lpsse_pkg::PROD_W'(s1_blue_reg) * gain_wide;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: divide by 255, swap, encode symbols, invert
    // ------------------------------------------------------------------
    logic [lpsse_pkg::FRAME_W-1:0] s3_frame_reg, s3_frame_next;
    logic [lpsse_pkg::CHAN_W-1:0]  q_red;
    logic [lpsse_pkg::CHAN_W-1:0]  q_green;
    logic [lpsse_pkg::CHAN_W-1:0]  q_blue;
    logic [lpsse_pkg::CHAN_W-1:0]  slot_red;
    logic [lpsse_pkg::CHAN_W-1:0]  slot_green;
    logic [lpsse_pkg::FRAME_W-1:0] frame_raw;

    assign q_red      = lpsse_pkg::div255(s2_red_reg);
    assign q_green    = lpsse_pkg::div255(s2_green_reg);
    assign q_blue     = lpsse_pkg::div255(s2_blue_reg);
    assign slot_red   = cfg_reg.swap_red_green ? q_green : q_red;
    assign slot_green = cfg_reg.swap_red_green ? q_red : q_green;

    // Red slot occupies the low bytes so it goes out first
    assign frame_raw = {
        lpsse_pkg::encode_channel(q_blue, cfg_reg.one_symbol, cfg_reg.zero_symbol),
        lpsse_pkg::encode_channel(slot_green, cfg_reg.one_symbol, cfg_reg.zero_symbol),
        lpsse_pkg::encode_channel(slot_red, cfg_reg.one_symbol, cfg_reg.zero_symbol)
    };

    always_comb
    begin
        s3_valid_next = s3_valid_reg;
        s3_frame_next = s3_frame_reg;
        if (s3_ready)
        begin
            s3_valid_next = s2_valid_reg;
            s3_frame_next = cfg_reg.invert_bytes ? ~frame_raw : frame_raw;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: byte serializer, doubles as the output register
    // ------------------------------------------------------------------
    always_comb
    begin
        ser_valid_next = ser_valid_reg;
        ser_cnt_next   = ser_cnt_reg;
        ser_frame_next = ser_frame_reg;
        if (ser_ready)
        begin
            ser_valid_next = s3_valid_reg;
            ser_cnt_next   = '0;
            ser_frame_next = s3_frame_reg;
        end
        else if (out_xfer)
        begin
            // Advance to the next byte of this pixel
            ser_cnt_next   = ser_cnt_inc;
            ser_frame_next = ser_frame_reg >> 8;
        end
    end

    assign stream.valid       = ser_valid_reg;
    assign stream.line_byte   = ser_frame_reg[7:0];
    assign stream.last_of_led = ser_last;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            ser_valid_reg <= 1'b0;
            ser_cnt_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            ser_valid_reg <= ser_valid_next;
            ser_cnt_reg   <= ser_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_red_reg    <= s1_red_next;
        s1_green_reg  <= s1_green_next;
        s1_blue_reg   <= s1_blue_next;
        s2_red_reg    <= s2_red_next;
        s2_green_reg  <= s2_green_next;
        s2_blue_reg   <= s2_blue_next;
        s3_frame_reg  <= s3_frame_next;
        ser_frame_reg <= ser_frame_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LPSSE_ASSERT_SAME(a_cnt_range, ser_valid_reg, ser_cnt_reg <= lpsse_pkg::CNT_LAST)
    `LPSSE_ASSERT_NEXT(a_in_lands, pixel.valid && pixel.ready, s1_valid_reg)
    `LPSSE_ASSERT_NEXT(a_byte_step, out_xfer && !ser_last, ser_cnt_reg == $past(ser_cnt_inc))
    `LPSSE_ASSERT_NEXT(a_stall_hold, out_stall, ser_valid_reg && $stable(ser_cnt_reg))

endmodule

### test/led_pixel_spi_symbol_encoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED pixel symbol encoder testbench
// Streams RGB pixels through the encoder under random source gaps and sink
// stalls. A scoreboard predicts the nine serial bytes of every pixel from a
// local copy of the configuration registers and compares each byte transfer.
// ----------------------------------------------------------------------------
module led_pixel_spi_symbol_encoder_test;

    localparam int unsigned FULL_SCALE     = 255;
    localparam int unsigned BYTES_PER_WORD = lpsse_pkg::WORD_W / 8;
    localparam int unsigned REG_COUNT      = 5;
    localparam int unsigned DRAIN_SLACK    = 8;
    localparam int unsigned END_SLACK      = 16;
    localparam int unsigned RANDOM_PHASES  = 6;
    localparam int unsigned PHASE_PIXELS   = 47;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       last_of_led;
    } led_byte_t;

    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic clk;
    logic rst_n;

    lpsse_pixel_if pix_ch ();
    lpsse_byte_if  byte_ch ();
    lpsse_cfg_if   cfg_ch ();

    led_pixel_spi_symbol_encoder u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix_ch),
        .stream (byte_ch),
        .cfg    (cfg_ch)
    );

    // Shadow copy of the configuration registers
    logic [lpsse_pkg::CHAN_W-1:0] dim_level;
    logic                         swap_rg;
    logic                         invert_out;
    logic [lpsse_pkg::SYM_W-1:0]  one_pat;
    logic [lpsse_pkg::SYM_W-1:0]  zero_pat;

    // Serial bytes still owed by the encoder, oldest first
    led_byte_t led_bytes_due[$];
    int        fail_count;

    // Sender pacing
    bit        gaps_on;
    int        burst_left;

    // Receiver long hold-off request, picked up by the receiver process
    int        rx_hold_req;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Scale one channel by the brightness, rounding down
    function automatic logic [lpsse_pkg::CHAN_W-1:0] dim_channel(
        input logic [lpsse_pkg::CHAN_W-1:0] level
    );
        int unsigned prod;
        prod = int'(level) * int'(dim_level);
        return lpsse_pkg::CHAN_W'(prod / FULL_SCALE);
    endfunction

    // Build the symbol word MSB symbol first, shifting earlier symbols toward the high end
    function automatic logic [lpsse_pkg::WORD_W-1:0] symbol_word(
        input logic [lpsse_pkg::CHAN_W-1:0] level
    );
        logic [lpsse_pkg::WORD_W-1:0] w;
        int                           b;
        w = '0;
        for (b = lpsse_pkg::CHAN_W - 1; b >= 0; b--)
        begin
            w = (w << lpsse_pkg::SYM_W) | lpsse_pkg::WORD_W'(level[b] ? one_pat : zero_pat);
        end
        return w;
    endfunction

    function automatic void queue_led_bytes(
        input logic [lpsse_pkg::CHAN_W-1:0] r,
        input logic [lpsse_pkg::CHAN_W-1:0] g,
        input logic [lpsse_pkg::CHAN_W-1:0] b
    );
        logic [lpsse_pkg::CHAN_W-1:0] slot [3];
        logic [lpsse_pkg::WORD_W-1:0] words [3];
        led_byte_t                    e;
        int                           k;
        slot[0] = dim_channel(swap_rg ? g : r);
        slot[1] = dim_channel(swap_rg ? r : g);
        slot[2] = dim_channel(b);
        for (k = 0; k < 3; k++)
        begin
            words[k] = symbol_word(slot[k]);
        end
        for (k = 0; k < lpsse_pkg::LED_BYTES; k++)
        begin
            e.line_byte   = 8'(words[k / BYTES_PER_WORD] >> (8 * (k % BYTES_PER_WORD)));
            if (invert_out)
            begin
                e.line_byte = ~e.line_byte;
            end
            e.last_of_led = (k == lpsse_pkg::LED_BYTES - 1);
            led_bytes_due.push_back(e);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Byte checker: compare every byte transfer with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        led_byte_t want;
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            if (led_bytes_due.size() == 0)
            begin
                $error("unexpected byte transfer: line_byte %h last_of_led %b",
                       byte_ch.line_byte, byte_ch.last_of_led);
                fail_count++;
            end
            else
            begin
                want = led_bytes_due.pop_front();
                if (byte_ch.line_byte !== want.line_byte)
                begin
                    $error("line_byte mismatch: expected %h, actual %h",
                           want.line_byte, byte_ch.line_byte);
                    fail_count++;
                end
                if (byte_ch.last_of_led !== want.last_of_led)
                begin
                    $error("last_of_led mismatch: expected %b, actual %b",
                           want.last_of_led, byte_ch.last_of_led);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall on a pattern that changes mode at random intervals,
    // and honor a long hold-off when a test asks for one
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        static rx_mode_t rx_mode  = RX_ALWAYS;
        static int       mode_left = 0;
        static int       hold_left = 0;
        static int       tick      = 0;
        tick++;
        if (rx_hold_req != 0)
        begin
            hold_left   = rx_hold_req;
            rx_hold_req = 0;
        end
        if (mode_left == 0)
        begin
            rx_mode   = rx_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(40, 100);
        end
        mode_left--;
        if (!rst_n)
        begin
            byte_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            // Count down the hold-off while the pipeline backs up
            hold_left--;
            byte_ch.ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS:   byte_ch.ready <= 1'b1;
                RX_MOSTLY:   byte_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE:   byte_ch.ready <= ($urandom_range(0, 9) < 3);
                default:     byte_ch.ready <= (tick % 5 != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Shared driver tasks; each one starts and ends at a falling edge
    // ------------------------------------------------------------------------

    // Drop valid for a random gap at the end of each random-length burst
    task automatic pace_sender();
        int gap;
        if (!gaps_on)
        begin
            return;
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 5))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(12, 30);
                default: gap = $urandom_range(1, 6);
            endcase
            if (gap > 0)
            begin
                pix_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Offer one pixel and hold it until the transfer; valid stays high for
    // the next pixel unless the pacing drops it
    task automatic send_pixel(
        input logic [lpsse_pkg::CHAN_W-1:0] r,
        input logic [lpsse_pkg::CHAN_W-1:0] g,
        input logic [lpsse_pkg::CHAN_W-1:0] b
    );
        pix_ch.valid <= 1'b1;
        pix_ch.red   <= r;
        pix_ch.green <= g;
        pix_ch.blue  <= b;
        @(posedge clk);
        while (!pix_ch.ready)
        begin
            @(posedge clk);
        end
        queue_led_bytes(r, g, b);
        @(negedge clk);
        pace_sender();
    endtask

    // Stop offering pixels and wait until every predicted byte has left
    task automatic wait_drained();
        pix_ch.valid <= 1'b0;
        while (led_bytes_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_SLACK) @(negedge clk);
    endtask

    // One register write; the shadow copy masks the value to the register width
    task automatic write_reg(
        input logic [lpsse_pkg::IDX_W-1:0] idx,
        input logic [7:0]                  value
    );
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        case (idx)
            lpsse_pkg::REG_BRIGHTNESS: dim_level  = value[lpsse_pkg::CHAN_W-1:0];
            lpsse_pkg::REG_SWAP_RG:    swap_rg    = value[0];
            lpsse_pkg::REG_INVERT:     invert_out = value[0];
            lpsse_pkg::REG_ONE_SYM:    one_pat    = value[lpsse_pkg::SYM_W-1:0];
            lpsse_pkg::REG_ZERO_SYM:   zero_pat   = value[lpsse_pkg::SYM_W-1:0];
            default:                   ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly uniform levels, the rest zero, one or full scale
    function automatic logic [lpsse_pkg::CHAN_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return lpsse_pkg::CHAN_W'(1);
            default: return lpsse_pkg::CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Pixels under the reset configuration: half brightness, plain symbols
    task automatic test_reset_defaults();
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hAA, 8'h55, 8'h0F);
        send_pixel(8'h01, 8'h80, 8'hFE);
        wait_drained();
    endtask

    // Brightness at zero, one, just below full and full
    task automatic test_brightness_scaling();
        write_reg(lpsse_pkg::REG_BRIGHTNESS, 8'h00);
        send_pixel(8'hFF, 8'h80, 8'h01);
        wait_drained();
        write_reg(lpsse_pkg::REG_BRIGHTNESS, 8'h01);
        send_pixel(8'hFF, 8'hFE, 8'h01);
        wait_drained();
        write_reg(lpsse_pkg::REG_BRIGHTNESS, 8'hFE);
        send_pixel(8'hFF, 8'h81, 8'h7F);
        wait_drained();
        write_reg(lpsse_pkg::REG_BRIGHTNESS, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h5A);
        send_pixel(8'h00, 8'hFF, 8'hA5);
        wait_drained();
    endtask

    // Red/green exchange, byte inversion and extreme symbol patterns
    task automatic test_symbols_swap_invert();
        write_reg(lpsse_pkg::REG_SWAP_RG, 8'h01);
        send_pixel(8'hF0, 8'h0F, 8'h3C);
        wait_drained();
        write_reg(lpsse_pkg::REG_INVERT, 8'h01);
        send_pixel(8'hF0, 8'h0F, 8'hC3);
        wait_drained();
        write_reg(lpsse_pkg::REG_ONE_SYM, 8'h07);
        write_reg(lpsse_pkg::REG_ZERO_SYM, 8'h00);
        send_pixel(8'hA5, 8'h5A, 8'hFF);
        wait_drained();
        write_reg(lpsse_pkg::REG_INVERT, 8'h00);
        write_reg(lpsse_pkg::REG_ONE_SYM, 8'h00);
        write_reg(lpsse_pkg::REG_ZERO_SYM, 8'h07);
        send_pixel(8'hA5, 8'h5A, 8'h00);
        wait_drained();
        // Same pattern for both bit values: every symbol slot is identical
        write_reg(lpsse_pkg::REG_ONE_SYM, 8'h05);
        write_reg(lpsse_pkg::REG_ZERO_SYM, 8'h05);
        send_pixel(8'h12, 8'h34, 8'h56);
        wait_drained();
    endtask

    // Values wider than a register and writes to unused indexes
    task automatic test_register_writes();
        int idx;
        write_reg(lpsse_pkg::REG_SWAP_RG, 8'hFE);
        write_reg(lpsse_pkg::REG_INVERT, 8'hFF);
        write_reg(lpsse_pkg::REG_ONE_SYM, 8'hF9);
        write_reg(lpsse_pkg::REG_ZERO_SYM, 8'hFA);
        write_reg(lpsse_pkg::REG_BRIGHTNESS, 8'hC8);
        send_pixel(8'hFF, 8'h01, 8'h80);
        wait_drained();
        // Unused indexes must leave every register alone
        for (idx = REG_COUNT; idx < (1 << lpsse_pkg::IDX_W); idx++)
        begin
            write_reg(lpsse_pkg::IDX_W'(idx), 8'hFF);
            write_reg(lpsse_pkg::IDX_W'(idx), 8'h00);
        end
        send_pixel(8'h3C, 8'hC3, 8'h99);
        wait_drained();
    endtask

    // Hold the output off long enough that the encoder stalls its input,
    // while pixels keep coming back to back
    task automatic test_output_backpressure();
        int n;
        write_reg(lpsse_pkg::REG_BRIGHTNESS, 8'hFF);
        write_reg(lpsse_pkg::REG_SWAP_RG, 8'h00);
        write_reg(lpsse_pkg::REG_INVERT, 8'h00);
        write_reg(lpsse_pkg::REG_ONE_SYM, 8'h06);
        write_reg(lpsse_pkg::REG_ZERO_SYM, 8'h04);
        gaps_on     = 1'b0;
        rx_hold_req = 300;
        for (n = 0; n < 14; n++)
        begin
            send_pixel(pick_level(), pick_level(), pick_level());
        end
        gaps_on = 1'b1;
        wait_drained();
    endtask

    // Random pixels over several random configurations
    task automatic test_random_pixels();
        int phase;
        int n;
        logic [7:0] level;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            // Walk brightness through its extremes before going random
            case (phase)
                0:       level = 8'h00;
                1:       level = 8'hFF;
                2:       level = 8'h01;
                3:       level = 8'hFE;
                default: level = 8'($urandom_range(0, 255));
            endcase
            write_reg(lpsse_pkg::REG_BRIGHTNESS, level);
            write_reg(lpsse_pkg::REG_SWAP_RG, 8'($urandom_range(0, 255)));
            write_reg(lpsse_pkg::REG_INVERT, 8'($urandom_range(0, 255)));
            write_reg(lpsse_pkg::REG_ONE_SYM, 8'($urandom_range(0, 255)));
            write_reg(lpsse_pkg::REG_ZERO_SYM, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 1)
            begin
                write_reg(lpsse_pkg::IDX_W'($urandom_range(REG_COUNT,
                                                           (1 << lpsse_pkg::IDX_W) - 1)),
                          8'($urandom_range(0, 255)));
            end
            for (n = 0; n < PHASE_PIXELS; n++)
            begin
                send_pixel(pick_level(), pick_level(), pick_level());
            end
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        pix_ch.valid  = 1'b0;
        pix_ch.red    = '0;
        pix_ch.green  = '0;
        pix_ch.blue   = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        byte_ch.ready = 1'b0;
        dim_level     = lpsse_pkg::BRIGHTNESS_RST;
        swap_rg       = 1'b0;
        invert_out    = 1'b0;
        one_pat       = lpsse_pkg::ONE_SYM_RST;
        zero_pat      = lpsse_pkg::ZERO_SYM_RST;
        fail_count    = 0;
        gaps_on       = 1'b1;
        burst_left    = 0;
        rx_hold_req   = 0;

        // Hold reset, then release it on a falling edge
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_brightness_scaling();
        test_symbols_swap_invert();
        test_register_writes();
        test_output_backpressure();
        test_random_pixels();

        // Let any stray byte surface before the verdict
        wait_drained();
        repeat (END_SLACK) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
